// ===== rtl/core/sorted_insert_priority_queue_macros.svh =====
// Assertion helpers shared by the queue modules.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/siq_pkg.sv =====
package siq_pkg;

    // Field widths of one queue entry.
    localparam int PRICE_W = 28;
    localparam int ID_W    = 8;
    localparam int DIST_W  = 28;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL_DROP = 2'd1;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd2;

    // One queue entry.
    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [ID_W-1:0]    prev_location;
        logic [ID_W-1:0]    location;
        logic [PRICE_W-1:0] price;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// Channel   Dir  Beat contents (lowest bit first)
// s_*       in   tuser: command; tdata: price, location_id, prev_location_id, distance
// m_*       out  tuser: is_empty, status; tdata: head fields, entry_count
//
// Each command takes the beat, then updates the sorted entry row, then
// presents the result, which it holds until the result beat is taken.
// All cells compare their key with the new key at once, so the cost does not
// grow with QUEUE_DEPTH. Reset clears the count; entries need no clearing.
// A stalled result holds the block; no new beat is taken until it leaves.

module sorted_insert_priority_queue
    import siq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // price[27:0], location_id[35:28],
                                   // prev_location_id[43:36], distance[71:44]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // head_price[27:0], head_location[35:28],
                                   // head_prev_location[43:36], head_distance[71:44],
                                   // entry_count[76:72], zero fill[79:77]
    output logic [2:0]  m_tuser    // is_empty[0], status[2:1]
);

    ctrl_cmd_t          cmd;
    entry_t             in_entry;
    entry_t             head;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  status;

    // Unpack the input beat.
    assign in_entry.price         = s_tdata[27:0];
    assign in_entry.location      = s_tdata[35:28];
    assign in_entry.prev_location = s_tdata[43:36];
    assign in_entry.distance      = s_tdata[71:44];

    siq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    siq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_command  (s_tuser),
        .in_entry    (in_entry),
        .head        (head),
        .is_empty    (is_empty),
        .entry_count (entry_count),
        .status      (status)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, entry_count, head.distance, head.prev_location,
                      head.location, head.price};
    assign m_tuser = {status, is_empty};

endmodule

// ===== rtl/core/siq_datapath.sv =====
`include "sorted_insert_priority_queue_macros.svh"

module siq_datapath
    import siq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  logic [CMD_W-1:0]     in_command,
    input  entry_t               in_entry,
    output entry_t               head,
    output logic                 is_empty,
    output logic [COUNT_W-1:0]   entry_count,
    output logic [STAT_W-1:0]    status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Captured command beat.
    logic [CMD_W-1:0]  command_reg;
    entry_t            new_reg;

    // Entry row, head at index zero, and its fill count.
    entry_t            entry_reg  [QUEUE_DEPTH];
    entry_t            entry_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    logic [QUEUE_DEPTH-1:0] ahead;
    logic                   head_tie;
    logic                   full;
    logic                   empty;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= in_command;
            new_reg     <= in_entry;
        end
    end

    // Each cell decides whether it lies ahead of the insert point. The cells
    // that hold a smaller key form a prefix; an equal head key also stays ahead.
    always_comb
    begin
        head_tie = !empty && (entry_reg[0].price == new_reg.price);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ahead[i] = (CNT_W'(i) < count_reg) && (entry_reg[i].price < new_reg.price);
        end
        ahead[0] = ahead[0] || head_tie;
    end

    // Next contents of the entry row and the count.
    always_comb
    begin
        count_next  = count_reg;
        status_next = STAT_DONE;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        case (command_reg)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL_DROP;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    // The head either stays or takes the new entry.
                    if (!ahead[0])
                    begin
                        entry_next[0] = new_reg;
                    end
                    for (int i = 1; i < QUEUE_DEPTH; i++)
                    begin
                        if (ahead[i])
                        begin
                            entry_next[i] = entry_reg[i];
                        end
                        else if (ahead[i-1])
                        begin
                            entry_next[i] = new_reg;
                        end
                        else
                        begin
                            entry_next[i] = entry_reg[i-1];
                        end
                    end
                end
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    status_next = STAT_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        entry_next[i] = entry_reg[i+1];
                    end
                end
            end
            default:
            begin
                status_next = STAT_DONE;
            end
        endcase
    end

    // Entry row update, no reset on payload.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    // Count and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= STAT_DONE;
        end
        else if (cmd.execute)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Result fields; the head reads as zero when nothing is held.
    assign is_empty    = empty;
    assign head        = empty ? '0 : entry_reg[0];
    assign entry_count = COUNT_W'(count_reg);
    assign status      = status_reg;

    `SIQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `SIQ_ASSERT_IMP(a_head_sorted, count_reg >= CNT_W'(2), entry_reg[0].price <= entry_reg[1].price, "head out of order")
    `SIQ_ASSERT_NEXT(a_drop_keeps, cmd.execute && status_next != STAT_DONE, $stable(count_reg), "count moved on a flagged command")

endmodule

// ===== rtl/core/siq_ctrl.sv =====
`include "sorted_insert_priority_queue_macros.svh"

module siq_ctrl
    import siq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state: take a beat, update the row, then hold the result.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake and datapath commands.
    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = (state_reg == ST_RESP);
    assign cmd.capture = s_tready && s_tvalid;
    assign cmd.execute = (state_reg == ST_EXEC);

    `SIQ_ASSERT_IMP(a_sides_apart, 1'b1, !(s_tready && m_tvalid), "input and output open together")
    `SIQ_ASSERT_NEXT(a_capture_exec, cmd.capture, cmd.execute, "captured beat not executed")
    `SIQ_ASSERT_NEXT(a_exec_result, cmd.execute, m_tvalid, "no result after update")

endmodule
